// File: rtl/core/csw_pkg.sv
// Shared types for the cascading sample wheels block.
// No dependencies; imported by every module of the block.
package csw_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT
  } csw_state_t;

  typedef struct packed {
    logic start;
    logic done;
  } csw_div_ctl_t;

endpackage

// File: rtl/core/csw_slot_ram.sv
// Slot memory: one write port, one read port, registered read data.
// Depends on csw_pkg.
module csw_slot_ram import csw_pkg::*; #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int DW    = 96
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/csw_const_div.sv
// Division by a fixed divisor through multiplication by its rounded-up reciprocal,
// one 32 by 32 bit partial product per cycle. Depends on csw_pkg for the control struct.
module csw_const_div import csw_pkg::*; #(
  parameter int DW      = 51,
  parameter int DIVISOR = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  csw_div_ctl_t  ctl_in,
  output csw_div_ctl_t  ctl_out,
  input  logic [DW-1:0] dividend,
  output logic [DW-1:0] quotient
);

  localparam int DG  = 32;
  localparam int SH  = $clog2(DIVISOR);
  localparam int MW  = DW + 2;
  localparam int XD  = (DW + DG - 1) / DG;
  localparam int MD  = (MW + DG - 1) / DG;
  localparam int XPW = XD * DG;
  localparam int MPW = MD * DG;
  localparam int XIW = (XD > 1) ? $clog2(XD) : 1;
  localparam int MJW = (MD > 1) ? $clog2(MD) : 1;
  localparam int ACW = (XD + MD) * DG;
  localparam logic [127:0] RECIP_FULL =
    ((128'd1 << (DW + SH)) + 128'(DIVISOR - 1)) / 128'(DIVISOR);
  localparam logic [MPW-1:0] RECIP = MPW'(RECIP_FULL);

  logic            busy;
  logic            done;
  logic [XIW-1:0]  xi;
  logic [MJW-1:0]  mj;
  logic [XPW-1:0]  dvd;
  logic [ACW-1:0]  acc;
  logic [DG-1:0]   x_dig;
  logic [DG-1:0]   m_dig;
  logic [2*DG-1:0] prod;
  logic [ACW-1:0]  term;
  logic            last_step;

  assign x_dig     = dvd[xi * DG +: DG];
  assign m_dig     = RECIP[mj * DG +: DG];
  assign prod      = {{DG{1'b0}}, x_dig} * {{DG{1'b0}}, m_dig};
  assign term      = ACW'(prod) << (DG * (int'(xi) + int'(mj)));
  assign last_step = (xi == XIW'(XD - 1)) && (mj == MJW'(MD - 1));
  assign quotient  = DW'(acc >> (DW + SH));

  always_comb begin
    ctl_out       = '0;
    ctl_out.done  = done;
    ctl_out.start = busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl_in.start) begin
        busy <= 1'b1;
      end else if (busy && last_step) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.start) begin
      dvd <= XPW'(dividend);
      acc <= '0;
      xi  <= '0;
      mj  <= '0;
    end else if (busy) begin
      acc <= acc + term;
      if (mj == MJW'(MD - 1)) begin
        mj <= '0;
        xi <= xi + XIW'(1);
      end else begin
        mj <= mj + MJW'(1);
      end
    end
  end

endmodule

// File: rtl/core/cascading_sample_wheels_top.sv
// Top level of the cascading sample wheels: sequencer over the slot memory.
// Depends on csw_pkg, csw_slot_ram and csw_const_div.
//
// Channel  | Direction | Handshake             | Payload
// sample   | in        | sample_valid / _stall | sample_delta
// result   | out       | result_valid / _stall | wheel_level, peak_delta, mean_value,
//          |           |                       | last_of_run
//
// A sample that fills no wheel passes only through the write step. Each roll-up adds a
// scan of the wheel's SLOTS_PER_WHEEL slots through the memory read port, the reciprocal
// multiply (32 by 32 bit partial products in turn, 4 at the default widths) and the
// divider start, wait and emit steps, with a write to the next wheel on all but the last.
// Reset clears the wheel positions and the handshake; slot memory is not cleared.
// A stalled result holds the sequencer in its emit step; the next sample is taken
// while the final result of a run still waits.
module cascading_sample_wheels_top import csw_pkg::*; #(
  parameter int SLOTS_PER_WHEEL = 8,
  parameter int WHEEL_COUNT     = 4,
  parameter int SAMPLE_BITS     = 48
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        sample_valid,
  output logic        sample_stall,
  input  logic [47:0] sample_delta,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  wheel_level,
  output logic [47:0] peak_delta,
  output logic [47:0] mean_value,
  output logic        last_of_run
);

  localparam int S     = SLOTS_PER_WHEEL;
  localparam int W     = WHEEL_COUNT;
  localparam int VW    = (SAMPLE_BITS < 48) ? SAMPLE_BITS : 48;
  localparam int PW    = $clog2(S);
  localparam int WW    = (W > 1) ? $clog2(W) : 1;
  localparam int DEPTH = W * S;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = VW + $clog2(S);
  localparam int HALF  = S / 2;

  csw_state_t state, state_next;

  logic [PW-1:0]   wheel_pos [W];
  logic [WW-1:0]   wheel;
  logic [VW-1:0]   cur_peak;
  logic [VW-1:0]   cur_mean;
  logic [PW:0]     rd_cnt;
  logic            rd_vld;
  logic            acc_first;
  logic [VW-1:0]   best;
  logic [SW-1:0]   sum;

  logic            ram_we;
  logic            ram_re;
  logic [AW-1:0]   base;
  logic [AW-1:0]   waddr;
  logic [AW-1:0]   raddr;
  logic [2*VW-1:0] rdata;
  logic [VW-1:0]   rd_peak;
  logic [VW-1:0]   rd_mean;

  csw_div_ctl_t    div_in;
  csw_div_ctl_t    div_out;
  logic [SW-1:0]   quotient;

  logic            cur_full;
  logic            wheel_last;
  logic            next_fills;
  logic            out_free;
  logic            scan_done;
  logic [WW:0]     wheel_inc;

  assign base       = AW'(wheel * S);
  assign waddr      = base + AW'(wheel_pos[wheel]);
  assign raddr      = base + AW'(rd_cnt[PW-1:0]);
  assign rd_peak    = rdata[2*VW-1:VW];
  assign rd_mean    = rdata[VW-1:0];
  assign cur_full   = (wheel_pos[wheel] == PW'(S - 1));
  assign wheel_inc  = {1'b0, wheel} + (WW+1)'(1);
  assign wheel_last = (wheel_inc == (WW+1)'(W));
  assign out_free   = !result_valid || !result_stall;
  assign scan_done  = rd_vld && (rd_cnt == (PW+1)'(S));

  always_comb begin
    next_fills = 1'b0;
    if (!wheel_last) begin
      next_fills = (wheel_pos[wheel_inc[WW-1:0]] == PW'(S - 1));
    end
  end

  csw_slot_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (2 * VW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata ({cur_peak, cur_mean}),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  csw_const_div #(
    .DW      (SW),
    .DIVISOR (S)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl_in   (div_in),
    .ctl_out  (div_out),
    .dividend (sum + SW'(HALF)),
    .quotient (quotient)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (sample_valid) state_next = ST_WRITE;
      ST_WRITE:     state_next = cur_full ? ST_SCAN : ST_IDLE;
      ST_SCAN:      if (scan_done) state_next = ST_DIV_START;
      ST_DIV_START: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT:  if (div_out.done) state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) state_next = wheel_last ? ST_IDLE : ST_WRITE;
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    sample_stall = 1'b1;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    div_in       = '0;
    unique case (state)
      ST_IDLE:      sample_stall = 1'b0;
      ST_WRITE:     ram_we = 1'b1;
      ST_SCAN:      ram_re = (rd_cnt != (PW+1)'(S));
      ST_DIV_START: div_in.start = 1'b1;
      ST_DIV_WAIT,
      ST_EMIT:      ;
      default:      ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      for (int i = 0; i < W; i++) begin
        wheel_pos[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (state == ST_WRITE) begin
        wheel_pos[wheel] <= cur_full ? '0 : wheel_pos[wheel] + PW'(1);
      end
      if (state == ST_EMIT && out_free) begin
        result_valid <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        cur_peak <= sample_delta[VW-1:0];
        cur_mean <= sample_delta[VW-1:0];
        wheel    <= '0;
      end
      ST_WRITE: begin
        rd_cnt    <= '0;
        rd_vld    <= 1'b0;
        acc_first <= 1'b1;
      end
      ST_SCAN: begin
        rd_vld <= ram_re;
        if (ram_re) begin
          rd_cnt <= rd_cnt + (PW+1)'(1);
        end
        if (rd_vld) begin
          acc_first <= 1'b0;
          if (acc_first) begin
            best <= rd_peak;
            sum  <= SW'(rd_mean);
          end else begin
            if (rd_peak > best) best <= rd_peak;
            sum <= sum + SW'(rd_mean);
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          wheel_level <= 2'(wheel);
          peak_delta  <= 48'(best);
          mean_value  <= 48'(quotient[VW-1:0]);
          last_of_run <= wheel_last || !next_fills;
          cur_peak    <= best;
          cur_mean    <= quotient[VW-1:0];
          wheel       <= wheel_inc[WW-1:0];
        end
      end
      ST_DIV_START,
      ST_DIV_WAIT: ;
      default: ;
    endcase
  end

endmodule
